FILE: rtl/vsrd_pkg.sv
// Shared widths and constants for the voxel span run decoder.
// No dependencies; imported by voxel_span_run_decoder_top and the testbench.
package vsrd_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned Z_W            = 9;
  localparam int unsigned IN_TDATA_W     = 3 * BYTE_W;
  localparam int unsigned OUT_TDATA_W    = 5 * BYTE_W;

  localparam logic [BYTE_W-1:0] HEIGHT_RESET = 8'd255;
  localparam logic [Z_W-1:0]    Z_MAX        = 9'd511;

  typedef logic [BYTE_W-1:0]      byte_t;
  typedef logic [Z_W-1:0]         zpos_t;
  typedef logic [IN_TDATA_W-1:0]  in_tdata_t;
  typedef logic [OUT_TDATA_W-1:0] out_tdata_t;

endpackage

FILE: rtl/voxel_span_run_decoder_top.sv
// Voxel span run decoder: decodes run-length span bytes of voxel columns.
// Depends on vsrd_pkg for widths, types and constants.
//
// Usage:
//   The slave stream carries one span byte per transaction. tdata holds
//   data_byte, column_x and column_y; tuser marks the first byte of a
//   column (column_start) and tlast marks the last byte available
//   (end_of_data). Each run is a skip byte that advances z, a count byte,
//   that many colour/normal byte pairs and one trailing byte. The master
//   stream carries one voxel (x, y, z, colour, normal) per transaction,
//   produced by the byte that holds the normal index.
//   The column height register is written through cfg_wr_en/cfg_wr_data
//   and must only be changed while the decoder is idle.
// Throughput and data path:
//   One byte per cycle while no voxel waits on a stalled result register. A
//   byte is captured in the input register and decoded there by a short
//   phase update and a 10-bit saturating add; a resulting voxel is then
//   registered in the result register, which drives the master side.
// Reset:
//   rst (synchronous) empties both registers, sets the column height to
//   255 and leaves the decoder waiting for a column start.
// Stall:
//   When the receiver holds tready low, the voxel waits in the result
//   register; the input register still takes a byte, and only a byte that
//   would produce another voxel waits there, which then stops tready.
module voxel_span_run_decoder_top (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: column_height
  input  logic                   cfg_wr_en,
  input  vsrd_pkg::byte_t        cfg_wr_data,
  // Slave stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  vsrd_pkg::in_tdata_t    s_axis_tdata,   // data_byte, column_x, column_y
  input  logic                   s_axis_tuser,   // column_start
  input  logic                   s_axis_tlast,   // end_of_data
  // Master stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output vsrd_pkg::out_tdata_t   m_axis_tdata    // voxel_x, voxel_y, voxel_z,
                                                 // color_index, normal_index
);
  import vsrd_pkg::*;

  // Decoder phases, in the order a run is read.
  typedef enum logic [2:0] {
    PH_DONE,
    PH_SKIP,
    PH_COUNT,
    PH_COLOR,
    PH_NORM,
    PH_TRAIL
  } phase_t;

  // Configuration register.
  byte_t   column_height;

  // Decoder state.
  phase_t  phase, phase_next;
  zpos_t   height_pos, height_pos_next;
  byte_t   voxels_left, voxels_left_next;
  byte_t   held_color, held_color_next;

  // Input register.
  logic    s1_valid;
  byte_t   s1_byte, s1_x, s1_y;
  logic    s1_start, s1_last;

  // Result register.
  logic        out_valid;
  out_tdata_t  out_data;

  logic    s_fire, s1_move, s1_fire, emit;
  phase_t  ph_eff;
  zpos_t   hp_eff;
  byte_t   vl_eff;
  logic [Z_W:0] skip_sum;
  zpos_t   hp_inc;
  byte_t   vl_dec;
  logic    more_room;

  // The input register drains unless it holds a voxel that cannot be
  // placed because the result register is full and stalled.
  assign s1_move       = !emit || !out_valid || m_axis_tready;
  assign s1_fire       = s1_valid && s1_move;
  assign s_axis_tready = !s1_valid || s1_move;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Single-pass decode of the byte in the input register.
  always_comb begin
    if (s1_start) begin
      hp_eff = '0;
      vl_eff = '0;
      ph_eff = (column_height != '0) ? PH_SKIP : PH_DONE;
    end else begin
      hp_eff = height_pos;
      vl_eff = voxels_left;
      ph_eff = phase;
    end

    skip_sum  = {1'b0, hp_eff} + {{(Z_W + 1 - BYTE_W){1'b0}}, s1_byte};
    hp_inc    = hp_eff + zpos_t'(1);
    vl_dec    = vl_eff - byte_t'(1);
    more_room = hp_inc < {1'b0, column_height};

    phase_next       = ph_eff;
    height_pos_next  = hp_eff;
    voxels_left_next = vl_eff;
    held_color_next  = held_color;
    emit             = 1'b0;

    case (ph_eff)
      PH_SKIP: begin
        height_pos_next = skip_sum[Z_W] ? Z_MAX : skip_sum[Z_W-1:0];
        phase_next      = PH_COUNT;
      end
      PH_COUNT: begin
        voxels_left_next = s1_byte;
        phase_next = (s1_byte != '0 && hp_eff < {1'b0, column_height}) ?
                     PH_COLOR : PH_TRAIL;
      end
      PH_COLOR: begin
        held_color_next = s1_byte;
        phase_next      = PH_NORM;
      end
      PH_NORM: begin
        emit             = 1'b1;
        height_pos_next  = hp_inc;
        voxels_left_next = vl_dec;
        phase_next = (vl_dec != '0 && more_room) ? PH_COLOR : PH_TRAIL;
      end
      PH_TRAIL: begin
        phase_next = (hp_eff < {1'b0, column_height}) ? PH_SKIP : PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    if (s1_last) begin
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_height <= HEIGHT_RESET;
      phase         <= PH_DONE;
      height_pos    <= '0;
      voxels_left   <= '0;
      held_color    <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        column_height <= cfg_wr_data;
      end

      if (s_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        phase       <= phase_next;
        height_pos  <= height_pos_next;
        voxels_left <= voxels_left_next;
        held_color  <= held_color_next;
      end

      if (s1_fire && emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_byte  <= s_axis_tdata[BYTE_W-1:0];
      s1_x     <= s_axis_tdata[2*BYTE_W-1:BYTE_W];
      s1_y     <= s_axis_tdata[3*BYTE_W-1:2*BYTE_W];
      s1_start <= s_axis_tuser;
      s1_last  <= s_axis_tlast;
    end
    if (s1_fire && emit) begin
      out_data <= {s1_byte, held_color, hp_eff[BYTE_W-1:0], s1_y, s1_x};
    end
  end

  // A byte flagged as the last of the data always closes the column.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (phase == PH_DONE))
    else $error("column not closed after end of data");

  // A column start with zero height never produces a voxel.
  a_zero_height: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_start && column_height == '0) |-> !emit)
    else $error("voxel emitted for zero-height column");

  // A finished column ignores bytes until the next column start.
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_start && phase == PH_DONE) |=>
      (phase == PH_DONE && $stable(height_pos) && !$rose(out_valid)))
    else $error("decoder active after column end");

  // A new voxel appears only from a byte that left the input register.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && emit))
    else $error("result without source byte");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for voxel_span_run_decoder_top: span bytes in, voxels out.
// Depends on vsrd_pkg and the decoder RTL; everything else, including the
// scoreboard class and its span decoder predictor, lives in this file.
module tb;
  import vsrd_pkg::*;

  // Decoding phases of the predictor. IDLE means the column is finished and
  // bytes are dropped until the next column start.
  typedef enum logic [2:0] {
    SPAN_IDLE,
    SPAN_SKIP,
    SPAN_COUNT,
    SPAN_COLOR,
    SPAN_NORMAL,
    SPAN_TRAIL
  } span_phase_t;

  // One emitted voxel, field by field.
  typedef struct packed {
    byte_t vx;
    byte_t vy;
    byte_t vz;
    byte_t color;
    byte_t normal;
  } voxel_t;

  // One byte of a column under construction, before it is sent.
  typedef struct packed {
    byte_t data;
    logic  start;
  } span_byte_t;

  // Scoreboard: predicts voxels from accepted span bytes and checks the ones
  // that come out of the block, oldest first.
  class voxel_scoreboard;
    byte_t       height;
    span_phase_t phase;
    zpos_t       zpos;
    byte_t       voxels_left;
    byte_t       held_color;
    voxel_t      pending_voxels[$];
    int unsigned errors;

    function new();
      height      = HEIGHT_RESET;
      phase       = SPAN_IDLE;
      zpos        = '0;
      voxels_left = '0;
      held_color  = '0;
      errors      = 0;
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
    endtask

    // Advances the decoder state by one accepted byte. Returns 1 when the byte
    // was decoded rather than dropped after the end of a column.
    function bit note_byte(byte_t d, bit start, bit eod, byte_t cx, byte_t cy);
      int unsigned sum;
      bit          taken;
      voxel_t      v;
      if (start) begin
        zpos        = '0;
        voxels_left = '0;
        phase       = (height != 0) ? SPAN_SKIP : SPAN_IDLE;
      end
      taken = (phase != SPAN_IDLE);
      case (phase)
        SPAN_SKIP: begin
          sum   = zpos + d;
          zpos  = (sum > Z_MAX) ? Z_MAX : zpos_t'(sum);
          phase = SPAN_COUNT;
        end
        SPAN_COUNT: begin
          voxels_left = d;
          phase = (voxels_left != 0 && zpos < height) ? SPAN_COLOR : SPAN_TRAIL;
        end
        SPAN_COLOR: begin
          held_color = d;
          phase      = SPAN_NORMAL;
        end
        SPAN_NORMAL: begin
          v.vx     = cx;
          v.vy     = cy;
          v.vz     = zpos[7:0];
          v.color  = held_color;
          v.normal = d;
          pending_voxels.insert(pending_voxels.size(), v);
          zpos        = zpos + 1'b1;
          voxels_left = voxels_left - 1'b1;
          phase = (voxels_left != 0 && zpos < height) ? SPAN_COLOR : SPAN_TRAIL;
        end
        SPAN_TRAIL: begin
          phase = (zpos < height) ? SPAN_SKIP : SPAN_IDLE;
        end
        default: begin
          phase = SPAN_IDLE;
        end
      endcase
      if (eod) begin
        phase = SPAN_IDLE;
      end
      return taken;
    endfunction

    task check_voxel(out_tdata_t t);
      voxel_t want;
      if (pending_voxels.size() == 0) begin
        report_mismatch("voxel with none expected, z", t[23:16], -1);
      end else begin
        want = pending_voxels.pop_front();
        if (t[7:0]   !== want.vx)     report_mismatch("voxel_x", t[7:0], want.vx);
        if (t[15:8]  !== want.vy)     report_mismatch("voxel_y", t[15:8], want.vy);
        if (t[23:16] !== want.vz)     report_mismatch("voxel_z", t[23:16], want.vz);
        if (t[31:24] !== want.color)  report_mismatch("color_index", t[31:24], want.color);
        if (t[39:32] !== want.normal) report_mismatch("normal_index", t[39:32], want.normal);
      end
    endtask
  endclass

  // Clock, reset and every block input start at known values.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  byte_t      cfg_wr_data = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  in_tdata_t  s_axis_tdata = '0;   // data_byte, column_x, column_y
  logic       s_axis_tuser = 1'b0; // column_start
  logic       s_axis_tlast = 1'b0; // end_of_data
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  out_tdata_t m_axis_tdata;        // voxel_x, voxel_y, voxel_z, color_index, normal_index

  voxel_scoreboard sb;
  bit              calm = 1'b0;     // when set, neither side inserts idle cycles
  bit              hold_req = 1'b0; // asks the receiver for a long hold-off
  int unsigned     hold_left = 0;
  int unsigned     taken_count = 0;
  int unsigned     sent_count = 0;

  voxel_span_run_decoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs or stops producing voxels.
  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver. Every transaction on the master side is checked against the
  // oldest predicted voxel. The values read here are the ones that were
  // present at this edge, since all drivers update with nonblocking
  // assignments. A hold-off request keeps tready low for a long stretch
  // that this process counts down itself.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_voxel(m_axis_tdata);
    end
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  // Offers one byte and waits for its transaction. Random idle cycles come
  // first, so gaps land on every decoding phase. tvalid is only lowered
  // when an idle cycle is inserted, never dropped and raised in one step.
  task automatic send_byte(byte_t d, bit start, bit eod, byte_t cx, byte_t cy);
    while (!calm && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cy, cx, d};
    s_axis_tuser  <= start;
    s_axis_tlast  <= eod;
    do @(posedge clk); while (!s_axis_tready);
    sent_count++;
    if (sb.note_byte(d, start, eod, cx, cy)) begin
      taken_count++;
    end
  endtask

  // Stops offering bytes and waits until every predicted voxel has come out,
  // then waits further for a byte that is still in the input register but
  // emits nothing.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_voxels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the column height while the decoder is idle.
  task automatic write_height(byte_t h);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.height = h;
  endtask

  // Builds one mostly well-formed column of random runs and sends it. Small
  // skips and counts keep most runs inside the column; now and then a large
  // skip or count runs past the top, a byte is replaced by noise, the
  // coordinates change mid-column, or the data ends early.
  task automatic send_column(int unsigned runs);
    span_byte_t  col[$];
    span_byte_t  b;
    byte_t       cx;
    byte_t       cy;
    int unsigned cnt;
    bit          ends_here;
    bit          eod;
    cx = byte_t'($urandom);
    cy = byte_t'($urandom);
    for (int unsigned r = 0; r < runs; r++) begin
      b.start = (r == 0);
      b.data  = ($urandom_range(0, 19) == 0) ? byte_t'($urandom) :
                byte_t'($urandom_range(0, 12));
      col.insert(col.size(), b);
      b.start = 1'b0;
      if ($urandom_range(0, 149) == 0) begin
        cnt = 255;
      end else if ($urandom_range(0, 29) == 0) begin
        cnt = $urandom_range(7, 40);
      end else begin
        cnt = $urandom_range(0, 6);
      end
      b.data = byte_t'(cnt);
      col.insert(col.size(), b);
      repeat (2 * cnt) begin
        b.data = byte_t'($urandom);
        col.insert(col.size(), b);
      end
      b.data = byte_t'($urandom);
      col.insert(col.size(), b);
    end
    ends_here = ($urandom_range(0, 5) == 0);
    foreach (col[i]) begin
      b = col[i];
      if ($urandom_range(0, 39) == 0) begin
        b.data = byte_t'($urandom);
      end
      if ($urandom_range(0, 39) == 0) begin
        cx = byte_t'($urandom);
        cy = byte_t'($urandom);
      end
      eod = (ends_here && i == col.size() - 1) || ($urandom_range(0, 79) == 0);
      send_byte(b.data, b.start, eod, cx, cy);
    end
  endtask

  // Main stimulus: reset, a short directed part, then random phases with
  // different column heights.
  initial begin
    byte_t       heights[8];
    int unsigned sent_cap;

    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first with the height left at its reset value.
    // A byte before any column start is dropped.
    send_byte(8'hAA, 1'b0, 1'b0, 8'h12, 8'h34);
    // Corner coordinates and extreme colour/normal values at z 0 and 1,
    // then a skip that jumps past the top: the count and trailing bytes are
    // taken without emitting and the column ends, so the last byte is dropped.
    send_byte(8'd0,   1'b1, 1'b0, 8'h00, 8'h00);
    send_byte(8'd2,   1'b0, 1'b0, 8'h00, 8'h00);
    send_byte(8'h00,  1'b0, 1'b0, 8'h00, 8'h00);
    send_byte(8'hFF,  1'b0, 1'b0, 8'h00, 8'h00);
    send_byte(8'hFF,  1'b0, 1'b0, 8'h00, 8'h00);
    send_byte(8'h00,  1'b0, 1'b0, 8'h00, 8'h00);
    send_byte(8'h5A,  1'b0, 1'b0, 8'h00, 8'h00);
    send_byte(8'd255, 1'b0, 1'b0, 8'h00, 8'h00);
    send_byte(8'd3,   1'b0, 1'b0, 8'h00, 8'h00);
    send_byte(8'h5A,  1'b0, 1'b0, 8'h00, 8'h00);
    send_byte(8'h77,  1'b0, 1'b0, 8'h00, 8'h00);
    // A count that runs past the top: two voxels at z 253 and 254, then the
    // next byte is the trailing byte and the column ends.
    send_byte(8'd253, 1'b1, 1'b0, 8'hFF, 8'hFF);
    send_byte(8'd5,   1'b0, 1'b0, 8'hFF, 8'hFF);
    send_byte(8'h11,  1'b0, 1'b0, 8'hFF, 8'hFF);
    send_byte(8'h22,  1'b0, 1'b0, 8'hFF, 8'hFF);
    send_byte(8'h33,  1'b0, 1'b0, 8'hFF, 8'hFF);
    send_byte(8'h44,  1'b0, 1'b0, 8'hFF, 8'hFF);
    send_byte(8'h55,  1'b0, 1'b0, 8'hFF, 8'hFF);
    send_byte(8'h66,  1'b0, 1'b0, 8'hFF, 8'hFF);
    // A column start in the middle of a run restarts decoding; the data then
    // ends on a normal byte, which still emits its voxel.
    send_byte(8'd1,   1'b1, 1'b0, 8'h0F, 8'hF0);
    send_byte(8'd2,   1'b0, 1'b0, 8'h0F, 8'hF0);
    send_byte(8'h80,  1'b0, 1'b0, 8'h0F, 8'hF0);
    send_byte(8'd0,   1'b1, 1'b0, 8'h0F, 8'hF0);
    send_byte(8'd1,   1'b0, 1'b0, 8'h0F, 8'hF0);
    send_byte(8'h01,  1'b0, 1'b0, 8'h0F, 8'hF0);
    send_byte(8'h02,  1'b0, 1'b1, 8'h0F, 8'hF0);
    // Data that ends on the skip byte of a new column.
    send_byte(8'd4,   1'b1, 1'b1, 8'h5A, 8'hA5);
    // Zero height: a column start ends the column at once.
    drain();
    write_height(8'd0);
    send_byte(8'd9,   1'b1, 1'b0, 8'h21, 8'h43);
    send_byte(8'd1,   1'b0, 1'b0, 8'h21, 8'h43);

    // Random phases. Each one starts from an idle block with a new height.
    // The drain between phases is also the point where the sender pauses
    // until every voxel has come out.
    heights = '{8'd255, 8'd60, 8'd1, 8'd0, 8'd255, 8'd20, 8'd0, 8'd128};
    heights[6] = byte_t'($urandom_range(2, 254));
    foreach (heights[p]) begin
      drain();
      write_height(heights[p]);
      // Phase 4 runs without any idle cycles on either side.
      calm = (p == 4);
      // In phase 1 the receiver holds off long enough for the block to fill
      // up and stall its input while bytes keep being offered.
      if (p == 1) begin
        hold_req = 1'b1;
      end
      taken_count = 0;
      sent_count  = 0;
      sent_cap = (heights[p] == 0) ? 20 : 150;
      while (taken_count < 50 && sent_count < sent_cap) begin
        send_column($urandom_range(1, 5));
      end
    end
    calm = 1'b0;

    drain();
    if (sb.pending_voxels.size() != 0) begin
      sb.report_mismatch("voxels never seen", 0, sb.pending_voxels.size());
    end
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/vsrd_pkg.sv
rtl/voxel_span_run_decoder_top.sv
verif/tb.sv
